// ===== sv/marching_squares_cell_classifier_unit_defines.svh =====
// assertion macros shared by the classifier rtl
`ifndef MARCHING_SQUARES_CELL_CLASSIFIER_UNIT_DEFINES_SVH
`define MARCHING_SQUARES_CELL_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MSCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mscc assertion failed");
// next-cycle implication
`define MSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mscc assertion failed");
`else
`define MSCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mscc_pkg.sv =====
// shared constants and types of the marching-squares cell classifier
package mscc_pkg;
  localparam int unsigned MAX_COLS_DEF    = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 12;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned ISO_W   = 16;
  localparam int unsigned RLEN_W  = 11;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned CASE_W  = 4;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [ROW_W-1:0]  ROW_MAX    = 12'hFFF;
  localparam logic [RLEN_W-1:0] RLEN_RESET = 11'd1024;
  localparam logic [RLEN_W-1:0] RLEN_MIN   = 11'd2;

  // corner weights and saddle codes
  localparam logic [CASE_W-1:0] CASE_TL     = 4'd8;
  localparam logic [CASE_W-1:0] CASE_TR     = 4'd4;
  localparam logic [CASE_W-1:0] CASE_BR     = 4'd2;
  localparam logic [CASE_W-1:0] CASE_BL     = 4'd1;
  localparam logic [CASE_W-1:0] CASE_SADDLE_A = 4'd5;
  localparam logic [CASE_W-1:0] CASE_SADDLE_B = 4'd10;

  // register index decoded from paddr[2]
  typedef enum logic [0:0] {
    REG_ISO  = 1'b0,
    REG_RLEN = 1'b1
  } reg_idx_e;
endpackage

// ===== sv/marching_squares_cell_classifier_unit.sv =====
// a sample goes through the front end window registers, the queue, the back end
// dividers and the output register; a full queue or stalled receiver holds it.
// The front end takes no new sample during its line buffer read, the back end no
// new cell before four shift-subtract dividers, one quotient bit per cycle, finish
// reset clears control state and config, not all data registers or the line buffer
module marching_squares_cell_classifier_unit import mscc_pkg::*; #(
  parameter int unsigned MAX_COLS    = MAX_COLS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_COLS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ROW_W-1:0]              cell_row_o,
  output logic [AW-1:0]                 cell_col_o,
  output logic [CASE_W-1:0]             case_id_o,
  output logic                          saddle_flipped_o,
  output logic [FRAC_BITS:0]            left_frac_o,
  output logic [FRAC_BITS:0]            top_frac_o,
  output logic [FRAC_BITS:0]            right_frac_o,
  output logic [FRAC_BITS:0]            bottom_frac_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready
);
  localparam int unsigned QW = ROW_W + AW + 4 * SAMPLE_BITS;

  logic [ISO_W-1:0]       iso_q;
  logic [RLEN_W-1:0]      rlen_q;
  reg_idx_e               ridx;
  logic                   push, full, pop, empty;
  logic                   q_push;
  logic [ROW_W-1:0]       f_row, b_row;
  logic [AW-1:0]          f_col, b_col;
  logic [SAMPLE_BITS-1:0] f_tl, f_tr, f_br, f_bl;
  logic [SAMPLE_BITS-1:0] b_tl, b_tr, b_br, b_bl;
  logic [QW-1:0]          q_din, q_dout;

  assign ridx   = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q  <= '0;
      rlen_q <= RLEN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_ISO:  iso_q  <= pwdata[ISO_W-1:0];
        REG_RLEN: rlen_q <= pwdata[RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (ridx)
      REG_ISO:  prdata = APB_DW'(iso_q);
      REG_RLEN: prdata = APB_DW'(rlen_q);
      default:  prdata = '0;
    endcase
  end

  mscc_front #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .frame_start_i (frame_start_i),
    .row_length_i  (rlen_q),
    .push_o        (push),
    .push_ready_i  (!full),
    .e_row_o       (f_row),
    .e_col_o       (f_col),
    .e_tl_o        (f_tl),
    .e_tr_o        (f_tr),
    .e_br_o        (f_br),
    .e_bl_o        (f_bl)
  );

  // window entry packing, a beat enters the queue only when there is room
  assign q_din  = {f_row, f_col, f_tl, f_tr, f_br, f_bl};
  assign q_push = push && !full;
  assign {b_row, b_col, b_tl, b_tr, b_br, b_bl} = q_dout;

  mscc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (q_dout),
    .empty_o (empty)
  );

  mscc_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .AW          (AW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (!empty),
    .pop_o            (pop),
    .e_row_i          (b_row),
    .e_col_i          (b_col),
    .e_tl_i           (b_tl),
    .e_tr_i           (b_tr),
    .e_br_i           (b_br),
    .e_bl_i           (b_bl),
    .iso_i            (iso_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cell_row_o       (cell_row_o),
    .cell_col_o       (cell_col_o),
    .case_id_o        (case_id_o),
    .saddle_flipped_o (saddle_flipped_o),
    .left_frac_o      (left_frac_o),
    .top_frac_o       (top_frac_o),
    .right_frac_o     (right_frac_o),
    .bottom_frac_o    (bottom_frac_o)
  );
endmodule

// ===== sv/mscc_ram.sv =====
// generic simple dual-port ram with registered read, read-first
module mscc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage and read register
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/mscc_front.sv =====
// front end: raster tracking, line buffer and 2x2 window assembly
module mscc_front import mscc_pkg::*; #(
  parameter int unsigned MAX_COLS    = MAX_COLS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_COLS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          frame_start_i,
  input  logic [RLEN_W-1:0]             row_length_i,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output logic [ROW_W-1:0]              e_row_o,
  output logic [AW-1:0]                 e_col_o,
  output logic [SAMPLE_BITS-1:0]        e_tl_o,
  output logic [SAMPLE_BITS-1:0]        e_tr_o,
  output logic [SAMPLE_BITS-1:0]        e_br_o,
  output logic [SAMPLE_BITS-1:0]        e_bl_o
);
  localparam int unsigned CNT_W = AW + 1;
  localparam int unsigned CMPW  = (CNT_W > RLEN_W) ? CNT_W : RLEN_W;

  typedef enum logic [0:0] {F_IDLE, F_READ} fstate_e;

  fstate_e                state_q;
  logic [AW-1:0]          col_q;
  logic [ROW_W-1:0]       row_q;
  logic                   have_above_q;
  logic [SAMPLE_BITS-1:0] left_now_q;
  logic [SAMPLE_BITS-1:0] left_above_q;
  logic                   emit_q;
  logic [ROW_W-1:0]       e_row_q;
  logic [AW-1:0]          e_col_q;
  logic [SAMPLE_BITS-1:0] tl_q, tr_q, bl_q;

  logic                   accept;
  logic [AW-1:0]          col_sel;
  logic [ROW_W-1:0]       row_sel;
  logic                   hab;
  logic [CMPW-1:0]        rlen_c;
  logic                   row_end;
  logic [SAMPLE_BITS-1:0] above;

  // window position after an optional frame restart, clamped row length and row end
  always_comb begin
    accept  = in_valid_i && (state_q == F_IDLE);
    col_sel = frame_start_i ? '0 : col_q;
    row_sel = frame_start_i ? '0 : row_q;
    hab     = !frame_start_i && have_above_q;
    if (row_length_i < RLEN_MIN) begin
      rlen_c = CMPW'(RLEN_MIN);
    end else if (CMPW'(row_length_i) > CMPW'(MAX_COLS)) begin
      rlen_c = CMPW'(MAX_COLS);
    end else begin
      rlen_c = CMPW'(row_length_i);
    end
    row_end = (CMPW'(col_sel) + CMPW'(1)) >= rlen_c;
  end

  // line buffer, old entry read while the new sample goes in
  mscc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_sel),
    .wdata_i (sample_i),
    .re_i    (accept),
    .raddr_i (col_sel),
    .rdata_o (above)
  );

  // state, raster counters and window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      col_q        <= '0;
      row_q        <= '0;
      have_above_q <= 1'b0;
      left_now_q   <= '0;
      left_above_q <= '0;
      emit_q       <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            emit_q     <= hab && (col_sel != '0);
            e_row_q    <= row_sel;
            e_col_q    <= col_sel - AW'(1);
            tl_q       <= left_now_q;
            tr_q       <= sample_i;
            bl_q       <= left_above_q;
            left_now_q <= sample_i;
            if (row_end) begin
              col_q <= '0;
              if (!hab) begin
                have_above_q <= 1'b1;
                row_q        <= row_sel;
              end else begin
                have_above_q <= 1'b1;
                row_q        <= (row_sel != ROW_MAX) ? row_sel + ROW_W'(1) : row_sel;
              end
            end else begin
              col_q        <= col_sel + AW'(1);
              row_q        <= row_sel;
              have_above_q <= hab;
            end
            state_q <= F_READ;
          end
        end
        F_READ: begin
          if (!emit_q || push_ready_i) begin
            left_above_q <= above;
            state_q      <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_READ) && emit_q;
  assign e_row_o    = e_row_q;
  assign e_col_o    = e_col_q;
  assign e_tl_o     = tl_q;
  assign e_tr_o     = tr_q;
  assign e_br_o     = above;
  assign e_bl_o     = bl_q;
endmodule

// ===== sv/mscc_queue.sv =====
// small fifo between the front and back ends
`include "marching_squares_cell_classifier_unit_defines.svh"
module mscc_queue import mscc_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [PW:0]      cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= din_i;
    end
  end

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = slot_q[rp_q];

  `MSCC_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `MSCC_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)
endmodule

// ===== sv/mscc_back.sv =====
// back end: case code, saddle flag and edge crossing dividers
`include "marching_squares_cell_classifier_unit_defines.svh"
module mscc_back import mscc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned AW          = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   pop_o,
  input  logic [ROW_W-1:0]       e_row_i,
  input  logic [AW-1:0]          e_col_i,
  input  logic [SAMPLE_BITS-1:0] e_tl_i,
  input  logic [SAMPLE_BITS-1:0] e_tr_i,
  input  logic [SAMPLE_BITS-1:0] e_br_i,
  input  logic [SAMPLE_BITS-1:0] e_bl_i,
  input  logic [ISO_W-1:0]       iso_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ROW_W-1:0]       cell_row_o,
  output logic [AW-1:0]          cell_col_o,
  output logic [CASE_W-1:0]      case_id_o,
  output logic                   saddle_flipped_o,
  output logic [FRAC_BITS:0]     left_frac_o,
  output logic [FRAC_BITS:0]     top_frac_o,
  output logic [FRAC_BITS:0]     right_frac_o,
  output logic [FRAC_BITS:0]     bottom_frac_o
);
  localparam int unsigned CW   = (SAMPLE_BITS > ISO_W) ? SAMPLE_BITS : ISO_W;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned RW   = CW + 2;
  localparam int unsigned CNTW = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_e;

  bstate_e            state_q;
  logic [CNTW-1:0]    cnt_q;
  logic [RW-1:0]      rem_q [4];
  logic [DW-1:0]      den_q [4];
  logic [FRAC_BITS:0] quo_q [4];
  logic               cross_q [4];
  logic [ROW_W-1:0]   row_q;
  logic [AW-1:0]      col_q;
  logic [CASE_W-1:0]  case_q;
  logic               flip_q;
  logic               out_valid_q;
  logic [ROW_W-1:0]   o_row_q;
  logic [AW-1:0]      o_col_q;
  logic [CASE_W-1:0]  o_case_q;
  logic               o_flip_q;
  logic [FRAC_BITS:0] o_frac_q [4];

  logic signed [CW-1:0] tl, tr, br, bl, iso;
  logic signed [CW-1:0] ea [4];
  logic signed [CW-1:0] eb [4];
  logic signed [RW-1:0] dn, dd;
  logic [DW-1:0]        num_c [4];
  logic [DW-1:0]        den_c [4];
  logic                 cross_c [4];
  logic signed [RW-1:0] sum_c, iso4;
  logic [CASE_W-1:0]    case_c;
  logic                 flip_c;
  logic                 ge_c [4];
  logic [RW-1:0]        rem_n [4];
  logic                 load_out;

  // corner classification and edge numerators and denominators
  always_comb begin
    tl  = CW'($signed(e_tl_i));
    tr  = CW'($signed(e_tr_i));
    br  = CW'($signed(e_br_i));
    bl  = CW'($signed(e_bl_i));
    iso = CW'($signed(iso_i));
    case_c = '0;
    if (tl >= iso) case_c = case_c | CASE_TL;
    if (tr >= iso) case_c = case_c | CASE_TR;
    if (br >= iso) case_c = case_c | CASE_BR;
    if (bl >= iso) case_c = case_c | CASE_BL;
    sum_c  = RW'(tl) + RW'(tr) + RW'(br) + RW'(bl);
    iso4   = RW'(iso) <<< 2;
    flip_c = ((case_c == CASE_SADDLE_A) || (case_c == CASE_SADDLE_B)) && (sum_c < iso4);
    ea[0] = bl; eb[0] = tl;
    ea[1] = tl; eb[1] = tr;
    ea[2] = br; eb[2] = tr;
    ea[3] = bl; eb[3] = br;
    dn = '0;
    dd = '0;
    for (int e = 0; e < 4; e++) begin
      cross_c[e] = (ea[e] >= iso) != (eb[e] >= iso);
      dn = RW'(iso) - RW'(ea[e]);
      dd = RW'(eb[e]) - RW'(ea[e]);
      num_c[e] = (dn < 0) ? DW'(-dn) : DW'(dn);
      den_c[e] = (dd < 0) ? DW'(-dd) : DW'(dd);
    end
  end

  // one restoring division step per edge
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      ge_c[e]  = rem_q[e] >= RW'(den_q[e]);
      rem_n[e] = ge_c[e] ? rem_q[e] - RW'(den_q[e]) : rem_q[e];
    end
  end

  assign pop_o    = (state_q == B_IDLE) && q_valid_i;
  assign load_out = (state_q == B_OUT) && (!out_valid_q || out_ready_i);

  // sequencer, dividers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            row_q  <= e_row_i;
            col_q  <= e_col_i;
            case_q <= case_c;
            flip_q <= flip_c;
            for (int e = 0; e < 4; e++) begin
              rem_q[e]   <= RW'(num_c[e]);
              den_q[e]   <= den_c[e];
              quo_q[e]   <= '0;
              cross_q[e] <= cross_c[e];
            end
            cnt_q   <= CNTW'(FRAC_BITS);
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          for (int e = 0; e < 4; e++) begin
            rem_q[e] <= rem_n[e] << 1;
            quo_q[e] <= {quo_q[e][FRAC_BITS-1:0], ge_c[e]};
          end
          if (cnt_q == '0) begin
            state_q <= B_OUT;
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
          end
        end
        B_OUT: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            o_row_q     <= row_q;
            o_col_q     <= col_q;
            o_case_q    <= case_q;
            o_flip_q    <= flip_q;
            for (int e = 0; e < 4; e++) begin
              o_frac_q[e] <= cross_q[e] ? quo_q[e] : HALF;
            end
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cell_row_o       = o_row_q;
  assign cell_col_o       = o_col_q;
  assign case_id_o        = o_case_q;
  assign saddle_flipped_o = o_flip_q;
  assign left_frac_o      = o_frac_q[0];
  assign top_frac_o       = o_frac_q[1];
  assign right_frac_o     = o_frac_q[2];
  assign bottom_frac_o    = o_frac_q[3];

  `MSCC_ASSERT_NEXT(a_pop_starts_div, clk_i, rst_ni, pop_o, state_q == B_DIV)
endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of the marching-squares cell classifier unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mscc_pkg::*;

  localparam int unsigned SBITS   = SAMPLE_BITS_DEF;
  localparam int unsigned FBITS   = FRAC_BITS_DEF;
  localparam int unsigned NCOLS   = MAX_COLS_DEF;
  localparam int unsigned CBITS   = $clog2(NCOLS);
  localparam int unsigned SETTLE  = 2 * (FBITS + 5) + 10;
  localparam int unsigned WD_MAX  = 3000;
  localparam int unsigned HOLD_LEN = 400;

  // one classified cell
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [CBITS-1:0]  col;
    logic [CASE_W-1:0] code;
    logic              flip;
    logic [FBITS:0]    left;
    logic [FBITS:0]    top;
    logic [FBITS:0]    right;
    logic [FBITS:0]    bottom;
  } cell_t;

  // grid tracker and expected-cell store
  class cell_scoreboard;
    longint            line_buf [NCOLS];
    longint            left_now;
    longint            left_above;
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    bit                row_above;
    logic signed [ISO_W-1:0] iso;
    logic [RLEN_W-1:0] rlen;
    cell_t             cells_due [$];
    int unsigned       errors;

    function new();
      foreach (line_buf[i]) line_buf[i] = 0;
      left_now = 0; left_above = 0; col_cnt = 0; row_cnt = 0; row_above = 0;
      iso = '0; rlen = RLEN_RESET; errors = 0;
    endfunction

    // crossing position of iso between a and b, scaled to one = 2**FBITS
    function logic [FBITS:0] crossing(longint a, longint b, longint lvl);
      longint num, den;
      if ((a >= lvl) == (b >= lvl)) return (FBITS+1)'(1 << (FBITS - 1));
      num = (lvl >= a) ? lvl - a : a - lvl;
      den = (b >= a) ? b - a : a - b;
      if (den == 0) return (FBITS+1)'(1 << (FBITS - 1));
      return (FBITS+1)'((num << FBITS) / den);
    endfunction

    function void note_sample(logic signed [SBITS-1:0] smp, logic fs);
      longint s, lvl, above, tl, tr, br, bl;
      int unsigned len, col;
      cell_t c;
      s = smp; lvl = iso; len = rlen;
      if (len < RLEN_MIN) len = RLEN_MIN;
      if (len > NCOLS) len = NCOLS;
      if (fs) begin
        col_cnt = 0; row_cnt = 0; row_above = 0;
      end
      col = (col_cnt >= NCOLS) ? NCOLS - 1 : col_cnt;
      above = line_buf[col];
      if (row_above && col >= 1) begin
        tl = left_now; tr = s; br = above; bl = left_above;
        c.code = '0;
        if (tl >= lvl) c.code |= CASE_TL;
        if (tr >= lvl) c.code |= CASE_TR;
        if (br >= lvl) c.code |= CASE_BR;
        if (bl >= lvl) c.code |= CASE_BL;
        c.flip = (c.code == CASE_SADDLE_A || c.code == CASE_SADDLE_B) &&
                 (tl + tr + br + bl < 4 * lvl);
        c.row    = row_cnt[ROW_W-1:0];
        c.col    = CBITS'(col - 1);
        c.left   = crossing(bl, tl, lvl);
        c.top    = crossing(tl, tr, lvl);
        c.right  = crossing(br, tr, lvl);
        c.bottom = crossing(bl, br, lvl);
        cells_due.insert(cells_due.size(), c);
      end
      left_above = above;
      line_buf[col] = s;
      left_now = s;
      if (col + 1 >= len) begin
        col_cnt = 0;
        if (!row_above) row_above = 1;
        else if (row_cnt < ROW_MAX) row_cnt++;
      end else begin
        col_cnt = col + 1;
      end
    endfunction

    function void check_cell(cell_t got);
      cell_t w;
      if (cells_due.size() == 0) begin
        $error("cell row %0d col %0d with none expected", got.row, got.col);
        errors++;
        return;
      end
      w = cells_due.pop_front();
      if (got.row != w.row) begin
        $error("cell_row expected %0d actual %0d", w.row, got.row); errors++;
      end
      if (got.col != w.col) begin
        $error("cell_col expected %0d actual %0d", w.col, got.col); errors++;
      end
      if (got.code != w.code) begin
        $error("case_id expected %0d actual %0d", w.code, got.code); errors++;
      end
      if (got.flip != w.flip) begin
        $error("saddle_flipped expected %0d actual %0d", w.flip, got.flip); errors++;
      end
      if (got.left != w.left) begin
        $error("left_frac expected %0d actual %0d", w.left, got.left); errors++;
      end
      if (got.top != w.top) begin
        $error("top_frac expected %0d actual %0d", w.top, got.top); errors++;
      end
      if (got.right != w.right) begin
        $error("right_frac expected %0d actual %0d", w.right, got.right); errors++;
      end
      if (got.bottom != w.bottom) begin
        $error("bottom_frac expected %0d actual %0d", w.bottom, got.bottom); errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [SBITS-1:0] sample_i = '0;
  logic                    frame_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [ROW_W-1:0]        cell_row_o;
  logic [CBITS-1:0]        cell_col_o;
  logic [CASE_W-1:0]       case_id_o;
  logic                    saddle_flipped_o;
  logic [FBITS:0]          left_frac_o, top_frac_o, right_frac_o, bottom_frac_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  cell_scoreboard grid_sb = new();
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  marching_squares_cell_classifier_unit i_dut (.*);

  always #10 clk_i = ~clk_i;

  // register write: setup then access cycle
  task automatic reg_write(reg_idx_e idx, logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_ISO) grid_sb.iso = val[ISO_W-1:0];
    else grid_sb.rlen = val[RLEN_W-1:0];
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // wait until every expected cell is out, then let the pipeline settle
  task automatic drain();
    in_valid_i = 1'b0;
    while (grid_sb.cells_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // offer one sample beat, with burst gaps on the sender side
  task automatic send_sample(logic signed [SBITS-1:0] s, logic fs);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i = 1'b1; sample_i = s; frame_start_i = fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    grid_sb.note_sample(s, fs);
    @(negedge clk_i);
  endtask

  // samples mostly around the threshold so edges cross often
  function automatic logic signed [SBITS-1:0] pick_sample();
    longint v;
    if ($urandom_range(0, 3) == 0) return SBITS'($urandom);
    v = longint'(grid_sb.iso) + $urandom_range(0, 4000) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SBITS'(v);
  endfunction

  task automatic random_frames(int unsigned n, bit mid_frames);
    for (int unsigned i = 0; i < n; i++)
      send_sample(pick_sample(), i == 0 || (mid_frames && $urandom_range(0, 250) == 0));
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int unsigned mode;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = $urandom_range(0, 1);
        default: out_ready_i = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      grid_sb.check_cell('{cell_row_o, cell_col_o, case_id_o, saddle_flipped_o,
                           left_frac_o, top_frac_o, right_frac_o, bottom_frac_o});
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_MAX) begin
      $display("[marching_squares_cell_classifier_unit] ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [SBITS-1:0] corner_pat [9];
    corner_pat = '{16'sh7FFF, -16'sd32768, 16'sd0,
                   -16'sd32768, 16'sh7FFF, 16'sd0,
                   16'sd100, -16'sd100, 16'sd1};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: 3x3 grids of extreme and near-zero samples at thresholds of zero and both extremes
    reg_write(REG_RLEN, 3);
    reg_write(REG_ISO, 0);
    for (int unsigned i = 0; i < 9; i++) send_sample(corner_pat[i], i == 0);
    drain();
    reg_write(REG_ISO, 32'h8000);
    for (int unsigned i = 0; i < 9; i++) send_sample(corner_pat[8 - i], i == 0);
    drain();
    reg_write(REG_ISO, 32'h7FFF);
    for (int unsigned i = 0; i < 9; i++) send_sample(corner_pat[i], i == 0);
    drain();

    // length below minimum acts as two
    reg_write(REG_ISO, $urandom_range(0, 65535));
    reg_write(REG_RLEN, 0);
    random_frames(24, 1);
    drain();

    // narrow rows with a long receiver hold-off while samples keep coming
    reg_write(REG_ISO, $urandom_range(0, 65535));
    reg_write(REG_RLEN, 5);
    random_frames(16, 1);
    hold_req = 1'b1;
    random_frames(90, 0);
    drain();

    // row length shrunk in the middle of a frame
    reg_write(REG_RLEN, 17);
    random_frames(40, 0);
    drain();
    reg_write(REG_RLEN, 6);
    for (int unsigned i = 0; i < 16; i++) send_sample(pick_sample(), 1'b0);
    drain();

    // length above maximum acts as full width
    reg_write(REG_ISO, 32'h7FFF);
    reg_write(REG_RLEN, 11'h7FF);
    random_frames(NCOLS + 8, 0);
    drain();

    // minimum width rows
    reg_write(REG_ISO, $urandom_range(0, 65535));
    reg_write(REG_RLEN, 1);
    random_frames(20, 0);

    drain();
    if (grid_sb.errors == 0 && grid_sb.cells_due.size() == 0)
      $display("[marching_squares_cell_classifier_unit] OK");
    else
      $display("[marching_squares_cell_classifier_unit] ERROR");
    $finish;
  end
endmodule

// ===== marching_squares_cell_classifier_unit.f =====
+incdir+sv
sv/mscc_pkg.sv
sv/mscc_ram.sv
sv/mscc_front.sv
sv/mscc_queue.sv
sv/mscc_back.sv
sv/marching_squares_cell_classifier_unit.sv
sim/tb_top.sv
